@@ rtl/core/bdln_pkg.sv @@
// ----------------------------------------------------------------------------
// bdln_pkg
// Shared types and constants for the battery drain and lead noise source.
// ----------------------------------------------------------------------------
package bdln_pkg;

    // input command codes
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // register indexes
    localparam logic [2:0] REG_NOMINAL = 3'd0;
    localparam logic [2:0] REG_ERI     = 3'd1;
    localparam logic [2:0] REG_EOL     = 3'd2;
    localparam logic [2:0] REG_AMP     = 3'd3;
    localparam logic [2:0] REG_WIDTH   = 3'd4;
    localparam logic [2:0] REG_FAULT   = 3'd5;
    localparam logic [2:0] REG_SEED    = 3'd6;

    // register reset values
    localparam logic [15:0] RST_NOMINAL = 16'd2800;
    localparam logic [15:0] RST_ERI     = 16'd2500;
    localparam logic [15:0] RST_EOL     = 16'd2200;
    localparam logic [15:0] RST_AMP     = 16'd3500;
    localparam logic [7:0]  RST_WIDTH   = 8'd1;
    localparam logic [15:0] RST_FAULT   = 16'd2500;
    localparam logic [31:0] RST_SEED    = 32'h9E37_79B9;

    // noise generator
    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [30:0] LCG_ADD = 31'd12345;

    // idle drain: dt / 20000, at most 3 for a 16-bit dt
    localparam int unsigned IDLE_DIV = 20000;
    localparam logic [15:0] IDLE_T1  = 16'(IDLE_DIV);
    localparam logic [15:0] IDLE_T2  = 16'(IDLE_DIV * 2);
    localparam logic [15:0] IDLE_T3  = 16'(IDLE_DIV * 3);

    // amplitude / 1000 as (amp * K_AMP) >> AMP_SHIFT, exact for 16-bit amp
    localparam logic [31:0] K_AMP     = 32'd67109;
    localparam int unsigned AMP_SHIFT = 26;

    // t / 25 as (t * K_25) >> 32, low by at most one for 27-bit t
    localparam logic [31:0] K_25     = 32'd171798691;
    localparam logic [4:0]  IMP_DIV  = 5'd25;

    // elapsed / 733000 as (e * K_FLT) >> 32, low by at most one
    localparam logic [31:0] K_FLT        = 32'd5859;
    localparam logic [31:0] FAULT_PERIOD = 32'd733000;
    localparam logic [20:0] FAULT_P21    = 21'(FAULT_PERIOD);

    // impedance bases
    localparam logic [15:0] A_BASE    = 16'd400;
    localparam logic [15:0] V_BASE    = 16'd450;
    localparam logic [15:0] A_RESTART = 16'd500;
    localparam logic [15:0] V_RESTART = 16'd550;

    // multiplier operand select
    typedef enum logic [2:0] {
        MS_AMP,
        MS_PACE,
        MS_LCG,
        MS_MOD,
        MS_FLT_Q,
        MS_FLT_M
    } t_mul_sel;

    // controller to datapath commands
    typedef struct packed {
        logic     capture;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     drain_en;
        logic     flag_en;
        logic     noise_en;
        logic     a_en;
        logic     v_en;
        logic     tick_out;
        logic     restart;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/core/battery_drain_lead_noise_model_top.sv @@
// ----------------------------------------------------------------------------
// battery_drain_lead_noise_model_top
// Simulated implant battery drain with sticky indicators and lead impedances.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ------------------------------
//  in        request    i_in_valid/o_in_stall  command, dt_ms, paced
//  out       result     o_out_valid/i_out_stall battery, flags, impedances
//  cfg       write      i_cfg_valid/o_cfg_ready index (3 bits), data (32 bits)
//
//  A tick request steps through one shared multiplier: pacing cost, two
//  noise steps, two residues by 400 and the fault residue. Reset is
//  synchronous, active low, and loads the register defaults.
//  A stalled result holds in the output register while the next request is
//  accepted; that request waits at its last step until the result is taken.
// ----------------------------------------------------------------------------
module battery_drain_lead_noise_model_top
    import bdln_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [15:0] i_dt_ms,
    input  logic        i_paced,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_battery_mv,
    output logic        o_eri_flag,
    output logic        o_eol_flag,
    output logic [15:0] o_atrial_impedance_ohms,
    output logic [15:0] o_ventricular_impedance_ohms,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    bdln_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_command),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    bdln_dp u_dp (
        .i_clk                        (i_clk),
        .i_rst_n                      (i_rst_n),
        .i_cmd                        (dp_cmd),
        .o_stat                       (dp_stat),
        .i_dt_ms                      (i_dt_ms),
        .i_paced                      (i_paced),
        .i_cfg_valid                  (i_cfg_valid),
        .i_cfg_index                  (i_cfg_index),
        .i_cfg_data                   (i_cfg_data),
        .o_out_valid                  (o_out_valid),
        .i_out_stall                  (i_out_stall),
        .o_battery_mv                 (o_battery_mv),
        .o_eri_flag                   (o_eri_flag),
        .o_eol_flag                   (o_eol_flag),
        .o_atrial_impedance_ohms      (o_atrial_impedance_ohms),
        .o_ventricular_impedance_ohms (o_ventricular_impedance_ohms)
    );

endmodule

@@ rtl/core/bdln_ctrl.sv @@
// ----------------------------------------------------------------------------
// bdln_ctrl
// Sequencer that steps one request through the shared multiplier datapath.
// ----------------------------------------------------------------------------
module bdln_ctrl
    import bdln_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_command,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0_0000_0000_0001,
        ST_RESTART = 13'b0_0000_0000_0010,
        ST_AMP     = 13'b0_0000_0000_0100,
        ST_PACE    = 13'b0_0000_0000_1000,
        ST_DRAIN   = 13'b0_0000_0001_0000,
        ST_S1      = 13'b0_0000_0010_0000,
        ST_M1      = 13'b0_0000_0100_0000,
        ST_R1      = 13'b0_0000_1000_0000,
        ST_S2      = 13'b0_0001_0000_0000,
        ST_M2      = 13'b0_0010_0000_0000,
        ST_R2      = 13'b0_0100_0000_0000,
        ST_F1      = 13'b0_1000_0000_0000,
        ST_F2      = 13'b1_0000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mul_sel = MS_AMP;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.capture = accept;
                if (accept) begin
                    n_state = (i_command == CMD_TICK) ? ST_AMP : ST_RESTART;
                end
            end
            ST_RESTART: begin
                if (i_stat.out_free) begin
                    o_cmd.restart = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_AMP: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_AMP;
                n_state = ST_PACE;
            end
            ST_PACE: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_PACE;
                n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                o_cmd.drain_en = 1'b1;
                o_cmd.mul_en   = 1'b1;
                o_cmd.mul_sel  = MS_LCG;
                n_state = ST_S1;
            end
            ST_S1: begin
                o_cmd.flag_en  = 1'b1;
                o_cmd.noise_en = 1'b1;
                n_state = ST_M1;
            end
            ST_M1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_MOD;
                n_state = ST_R1;
            end
            ST_R1: begin
                o_cmd.a_en    = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_LCG;
                n_state = ST_S2;
            end
            ST_S2: begin
                o_cmd.noise_en = 1'b1;
                n_state = ST_M2;
            end
            ST_M2: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_MOD;
                n_state = ST_R2;
            end
            ST_R2: begin
                o_cmd.v_en    = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_FLT_Q;
                n_state = ST_F1;
            end
            ST_F1: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MS_FLT_M;
                n_state = ST_F2;
            end
            ST_F2: begin
                if (i_stat.out_free) begin
                    o_cmd.tick_out = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/core/bdln_dp.sv @@
// ----------------------------------------------------------------------------
// bdln_dp
// Registers, battery state, shared multiplier, residue logic and result stage.
// ----------------------------------------------------------------------------
module bdln_dp
    import bdln_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    input  logic [15:0] i_dt_ms,
    input  logic        i_paced,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_battery_mv,
    output logic        o_eri_flag,
    output logic        o_eol_flag,
    output logic [15:0] o_atrial_impedance_ohms,
    output logic [15:0] o_ventricular_impedance_ohms
);

    // configuration
    logic [15:0] r_nominal;
    logic [15:0] r_eri_thr;
    logic [15:0] r_eol_thr;
    logic [15:0] r_amp;
    logic [7:0]  r_width;
    logic [15:0] r_fault;
    logic [31:0] r_seed;

    // model state
    logic [15:0] r_batt;
    logic        r_eri;
    logic        r_eol;
    logic [31:0] r_elapsed;
    logic [31:0] r_noise;

    // working registers
    logic [15:0] r_dt;
    logic        r_paced;
    logic [63:0] r_prod;
    logic [15:0] r_a_imp;
    logic [15:0] r_v_noise;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] n_prod;
    logic [1:0]  idle_mv;
    logic [15:0] pace_mv;
    logic [16:0] drain;
    logic [15:0] n_batt;
    logic [30:0] n_noise;
    logic [5:0]  q25_low;
    logic [5:0]  r6;
    logic [4:0]  r25;
    logic [8:0]  span_ofs;
    logic [20:0] r21;
    logic [19:0] fault_rem;
    logic        fault_hit;
    logic [15:0] v_imp;

    assign o_stat.out_free = !o_out_valid || !i_out_stall;

    // write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal <= RST_NOMINAL;
            r_eri_thr <= RST_ERI;
            r_eol_thr <= RST_EOL;
            r_amp     <= RST_AMP;
            r_width   <= RST_WIDTH;
            r_fault   <= RST_FAULT;
            r_seed    <= RST_SEED;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NOMINAL: r_nominal <= i_cfg_data[15:0];
                REG_ERI:     r_eri_thr <= i_cfg_data[15:0];
                REG_EOL:     r_eol_thr <= i_cfg_data[15:0];
                REG_AMP:     r_amp     <= i_cfg_data[15:0];
                REG_WIDTH:   r_width   <= i_cfg_data[7:0];
                REG_FAULT:   r_fault   <= i_cfg_data[15:0];
                REG_SEED:    r_seed    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // select multiplier operands
    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_AMP: begin
                mul_a = {16'b0, r_amp};
                mul_b = K_AMP;
            end
            MS_PACE: begin
                mul_a = {25'b0, r_prod[AMP_SHIFT+6:AMP_SHIFT]};
                mul_b = {23'b0, ({1'b0, r_width} + 9'd1)};
            end
            MS_LCG: begin
                mul_a = {1'b0, r_noise[30:0]};
                mul_b = LCG_MUL;
            end
            MS_MOD: begin
                mul_a = {5'b0, r_noise[30:4]};
                mul_b = K_25;
            end
            MS_FLT_Q: begin
                mul_a = r_elapsed;
                mul_b = K_FLT;
            end
            MS_FLT_M: begin
                mul_a = {19'b0, r_prod[44:32]};
                mul_b = FAULT_PERIOD;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        n_prod = {32'b0, mul_a} * {32'b0, mul_b};
    end

    // drain: idle share by threshold compare, pacing share from the product
    always_comb begin
        if (r_dt >= IDLE_T3) begin
            idle_mv = 2'd3;
        end else if (r_dt >= IDLE_T2) begin
            idle_mv = 2'd2;
        end else if (r_dt >= IDLE_T1) begin
            idle_mv = 2'd1;
        end else begin
            idle_mv = 2'd0;
        end
        if (!r_paced) begin
            pace_mv = 16'd0;
        end else if (r_prod[15:0] == 16'd0) begin
            pace_mv = 16'd1;
        end else begin
            pace_mv = r_prod[15:0];
        end
        drain = {15'b0, idle_mv} + {1'b0, pace_mv};
        n_batt = ({1'b0, r_batt} > drain) ? (r_batt - drain[15:0]) : 16'd0;
    end

    // noise step: low 31 bits of the product plus the increment
    assign n_noise = r_prod[30:0] + LCG_ADD;

    // residue of the upper noise bits by 25; the true remainder is below 50
    always_comb begin
        q25_low  = r_prod[37:32];
        r6       = r_noise[9:4] - ({q25_low[1:0], 4'b0} + {q25_low[2:0], 3'b0} + q25_low);
        r25      = (r6 >= {1'b0, IMP_DIV}) ? 5'(r6 - {1'b0, IMP_DIV}) : r6[4:0];
        span_ofs = {r25, r_noise[3:0]};
    end

    // fault window: elapsed mod period against dt
    always_comb begin
        r21       = r_elapsed[20:0] - r_prod[20:0];
        fault_rem = (r21 >= FAULT_P21) ? 20'(r21 - FAULT_P21) : r21[19:0];
        fault_hit = (fault_rem < {4'b0, r_dt});
        v_imp     = fault_hit ? r_fault : r_v_noise;
    end

    // hold request fields and working values
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_dt    <= i_dt_ms;
            r_paced <= i_paced;
        end
        if (i_cmd.mul_en) begin
            r_prod <= n_prod;
        end
        if (i_cmd.a_en) begin
            r_a_imp <= A_BASE + {7'b0, span_ofs};
        end
        if (i_cmd.v_en) begin
            r_v_noise <= V_BASE + {7'b0, span_ofs};
        end
    end

    // advance model state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_batt    <= RST_NOMINAL;
            r_eri     <= 1'b0;
            r_eol     <= 1'b0;
            r_elapsed <= '0;
            r_noise   <= RST_SEED;
        end else begin
            if (i_cmd.restart) begin
                r_batt    <= r_nominal;
                r_eri     <= 1'b0;
                r_eol     <= 1'b0;
                r_elapsed <= '0;
                r_noise   <= r_seed;
            end
            if (i_cmd.capture) begin
                r_elapsed <= r_elapsed + {16'b0, i_dt_ms};
            end
            if (i_cmd.drain_en) begin
                r_batt <= n_batt;
            end
            if (i_cmd.flag_en) begin
                if (r_batt <= r_eri_thr) begin
                    r_eri <= 1'b1;
                end
                if (r_batt <= r_eol_thr) begin
                    r_eol <= 1'b1;
                end
            end
            if (i_cmd.noise_en) begin
                r_noise <= {1'b0, n_noise};
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.restart || i_cmd.tick_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.restart) begin
            o_battery_mv                 <= r_nominal;
            o_eri_flag                   <= 1'b0;
            o_eol_flag                   <= 1'b0;
            o_atrial_impedance_ohms      <= A_RESTART;
            o_ventricular_impedance_ohms <= V_RESTART;
        end else if (i_cmd.tick_out) begin
            o_battery_mv                 <= r_batt;
            o_eri_flag                   <= r_eri;
            o_eol_flag                   <= r_eol;
            o_atrial_impedance_ohms      <= r_a_imp;
            o_ventricular_impedance_ohms <= v_imp;
        end
    end

endmodule

@@ rtl/core/bdln_chk.sv @@
// ----------------------------------------------------------------------------
// bdln_chk
// Port-level checks for the battery drain and lead noise source.
// ----------------------------------------------------------------------------
module bdln_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_battery_mv,
    input logic        o_eri_flag,
    input logic        o_eol_flag,
    input logic [15:0] o_atrial_impedance_ohms,
    input logic [15:0] o_ventricular_impedance_ohms
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_battery_mv)
            && $stable(o_eri_flag) && $stable(o_eol_flag)
            && $stable(o_atrial_impedance_ohms)
            && $stable(o_ventricular_impedance_ohms)))
        else $error("stalled result changed");

    // go busy after each accepted request
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while block still idle");

    // raise a new result only from a busy block
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in flight");

    // keep atrial impedance in its noise span or at the restart value
    a_atrial_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_atrial_impedance_ohms >= 16'd400
            && o_atrial_impedance_ohms <= 16'd799))
        else $error("atrial impedance out of range");

endmodule

bind battery_drain_lead_noise_model_top bdln_chk u_bdln_chk (.*);
